[sv/mrfr_pkg.sv]
// Shared types, codes and the helper function of the Modbus RTU frame receiver.
package mrfr_pkg;

   localparam int MAX_FRAME_BYTES_DEFAULT = 256;

   localparam logic [7:0]  OWN_ADDRESS_RESET  = 8'd255;
   localparam logic [15:0] BYTE_TIMEOUT_RESET = 16'd500;
   localparam logic [15:0] CRC_INIT           = 16'hFFFF;
   localparam logic [15:0] CRC_POLY           = 16'hA001;
   localparam logic [7:0]  BROADCAST_ADDRESS  = 8'd0;

   localparam logic CSR_OWN_ADDRESS  = 1'b0;
   localparam logic CSR_BYTE_TIMEOUT = 1'b1;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic [7:0] FC_WRITE_COILS     = 8'd15;
   localparam logic [7:0] FC_WRITE_REGISTERS = 8'd16;
   localparam logic [7:0] FC_MASK_WRITE      = 8'd22;
   localparam logic [7:0] FC_READ_WRITE      = 8'd23;
   localparam logic [7:0] FC_LAST_BASIC      = 8'd6;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_FUNC,
      PH_META,
      PH_DATA,
      PH_DROP
   } phase_type;

   typedef enum logic [2:0] {
      ST_BUSY,
      ST_OK,
      ST_NOT_US,
      ST_LONG,
      ST_CRC,
      ST_TIMEOUT
   } status_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] byte_out;
      logic [7:0] byte_position;
      logic       frame_end;
      status_type status;
      logic [7:0] function_code;
      logic [8:0] frame_length;
   } result_type;

   // Number of header bytes that follow the function code, zero for unknown codes.
   function automatic logic [3:0] meta_length(input logic [7:0] fc);
      logic [3:0] m;
      m = 4'd0;
      if (fc <= FC_LAST_BASIC) begin
         m = 4'd4;
      end else if (fc == FC_WRITE_COILS || fc == FC_WRITE_REGISTERS) begin
         m = 4'd5;
      end else if (fc == FC_MASK_WRITE) begin
         m = 4'd6;
      end else if (fc == FC_READ_WRITE) begin
         m = 4'd9;
      end
      return m;
   endfunction

endpackage

[sv/mrfr_crc.sv]
// Byte-wide update of the reflected CRC-16 used by Modbus RTU.
module mrfr_crc (
   input  logic [15:0] crc_old,
   input  logic [7:0]  data,
   output logic [15:0] crc_new
);

   always_comb begin
      logic [15:0] c;
      c = crc_old ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ mrfr_pkg::CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      crc_new = c;
   end

endmodule

[sv/mrfr_frame_fsm.sv]
// Frame state, length tracking, CRC check and timeout of the receiver.
module mrfr_frame_fsm #(
   parameter int MAX_FRAME_BYTES = mrfr_pkg::MAX_FRAME_BYTES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic                 cmd,
   input  logic [7:0]           rx_byte,
   input  logic [7:0]           own_address,
   input  logic [15:0]          byte_timeout_ticks,
   output mrfr_pkg::result_type result
);

   localparam logic [9:0] MAX_BYTES = 10'(MAX_FRAME_BYTES);

   mrfr_pkg::phase_type phase_ff, phase_in;
   logic [8:0]  rem_ff, rem_in;
   logic [8:0]  cnt_ff, cnt_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] one_back_ff, one_back_in;
   logic [15:0] last_ff, last_in;
   logic [7:0]  func_ff, func_in;
   logic [15:0] idle_ff, idle_in;

   logic                start;
   mrfr_pkg::phase_type e_phase;
   logic [8:0]          e_rem, e_cnt, rem_dec, new_cnt, data_len;
   logic [15:0]         e_crc, e_one, e_last, crc_next, idle_inc;
   logic [7:0]          e_func;
   logic [3:0]          meta;

   assign start  = (phase_ff == mrfr_pkg::PH_IDLE);
   assign e_phase = start ? mrfr_pkg::PH_FUNC : phase_ff;
   assign e_rem  = start ? 9'd2 : rem_ff;
   assign e_cnt  = start ? 9'd0 : cnt_ff;
   assign e_crc  = start ? mrfr_pkg::CRC_INIT : crc_ff;
   assign e_one  = start ? mrfr_pkg::CRC_INIT : one_back_ff;
   assign e_last = start ? 16'd0 : last_ff;
   assign e_func = start ? 8'd0 : func_ff;

   assign new_cnt  = e_cnt + 9'd1;
   assign rem_dec  = (e_rem != 9'd0) ? e_rem - 9'd1 : 9'd0;
   assign idle_inc = (idle_ff != 16'hFFFF) ? idle_ff + 16'd1 : idle_ff;
   assign meta     = mrfr_pkg::meta_length(rx_byte);

   mrfr_crc u_crc (
      .crc_old (e_crc),
      .data    (rx_byte),
      .crc_new (crc_next)
   );

   always_comb begin
      phase_in    = phase_ff;
      rem_in      = rem_ff;
      cnt_in      = cnt_ff;
      crc_in      = crc_ff;
      one_back_in = one_back_ff;
      last_in     = last_ff;
      func_in     = func_ff;
      idle_in     = idle_ff;
      data_len    = 9'd2;

      result.valid         = 1'b0;
      result.byte_out      = rx_byte;
      result.byte_position = e_cnt[7:0];
      result.frame_end     = 1'b0;
      result.status        = mrfr_pkg::ST_BUSY;
      result.function_code = func_ff;
      result.frame_length  = cnt_ff;

      if (cmd == mrfr_pkg::CMD_TICK) begin
         if (phase_ff == mrfr_pkg::PH_DROP) begin
            phase_in = mrfr_pkg::PH_IDLE;
            idle_in  = 16'd0;
         end else if (phase_ff != mrfr_pkg::PH_IDLE) begin
            idle_in = idle_inc;
            if (idle_inc >= byte_timeout_ticks) begin
               phase_in             = mrfr_pkg::PH_IDLE;
               idle_in              = 16'd0;
               result.valid         = 1'b1;
               result.byte_out      = 8'd0;
               result.byte_position = 8'd0;
               result.frame_end     = 1'b1;
               result.status        = mrfr_pkg::ST_TIMEOUT;
            end
         end
      end else if (phase_ff != mrfr_pkg::PH_DROP) begin
         phase_in    = e_phase;
         idle_in     = 16'd0;
         cnt_in      = new_cnt;
         rem_in      = rem_dec;
         crc_in      = crc_next;
         one_back_in = e_crc;
         last_in     = {e_last[7:0], rx_byte};
         func_in     = e_func;
         if (rem_dec == 9'd0) begin
            unique case (e_phase)
               mrfr_pkg::PH_FUNC: begin
                  func_in = rx_byte;
                  if (e_last[7:0] != own_address &&
                      e_last[7:0] != mrfr_pkg::BROADCAST_ADDRESS) begin
                     result.status    = mrfr_pkg::ST_NOT_US;
                     result.frame_end = 1'b1;
                     phase_in         = mrfr_pkg::PH_DROP;
                  end else if (meta != 4'd0) begin
                     rem_in   = {5'd0, meta};
                     phase_in = mrfr_pkg::PH_META;
                  end else if ({1'b0, new_cnt} + 10'd2 > MAX_BYTES) begin
                     result.status    = mrfr_pkg::ST_LONG;
                     result.frame_end = 1'b1;
                     phase_in         = mrfr_pkg::PH_IDLE;
                  end else begin
                     rem_in   = 9'd2;
                     phase_in = mrfr_pkg::PH_DATA;
                  end
               end
               mrfr_pkg::PH_META: begin
                  if (e_func == mrfr_pkg::FC_WRITE_COILS ||
                      e_func == mrfr_pkg::FC_WRITE_REGISTERS ||
                      e_func == mrfr_pkg::FC_READ_WRITE) begin
                     data_len = {1'b0, rx_byte} + 9'd2;
                  end
                  if ({1'b0, new_cnt} + {1'b0, data_len} > MAX_BYTES) begin
                     result.status    = mrfr_pkg::ST_LONG;
                     result.frame_end = 1'b1;
                     phase_in         = mrfr_pkg::PH_IDLE;
                  end else begin
                     rem_in   = data_len;
                     phase_in = mrfr_pkg::PH_DATA;
                  end
               end
               default: begin
                  // The CRC travels low byte first.
                  result.status    = (e_one == {rx_byte, e_last[7:0]}) ?
                                     mrfr_pkg::ST_OK : mrfr_pkg::ST_CRC;
                  result.frame_end = 1'b1;
                  phase_in         = mrfr_pkg::PH_IDLE;
               end
            endcase
         end
         result.valid         = 1'b1;
         result.function_code = func_in;
         result.frame_length  = new_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= mrfr_pkg::PH_IDLE;
         idle_ff  <= 16'd0;
         rem_ff   <= 9'd2;
         cnt_ff   <= 9'd0;
         func_ff  <= 8'd0;
      end else if (fire) begin
         phase_ff <= phase_in;
         idle_ff  <= idle_in;
         rem_ff   <= rem_in;
         cnt_ff   <= cnt_in;
         func_ff  <= func_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         crc_ff      <= crc_in;
         one_back_ff <= one_back_in;
         last_ff     <= last_in;
      end
   end

endmodule

[sv/modbus_rtu_frame_receiver_top.sv]
// Top level of the Modbus RTU frame receiver with input, output and CSR registers.
// A request is registered at its accepting edge and processed once the output register is free or being taken.
// Its result, if any, is registered when the request is processed and stays on rsp until it is taken.
// One request is accepted in every cycle unless a result waits with rsp_tready low.
// Synchronous reset returns to idle, own_address to 255 and the timeout to 500 ticks.
module modbus_rtu_frame_receiver_top #(
   parameter int MAX_FRAME_BYTES = mrfr_pkg::MAX_FRAME_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   input  logic        req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // byte_out, byte_position, status, function_code, frame_length, zero fill
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast,   // frame_end
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata
);

   logic        in_valid_ff;
   logic        in_cmd_ff;
   logic [7:0]  in_byte_ff;
   logic        out_valid_ff;
   mrfr_pkg::result_type out_ff;
   mrfr_pkg::result_type result;
   logic [7:0]  own_address_ff;
   logic [15:0] timeout_ff;
   logic        fire;

   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= mrfr_pkg::OWN_ADDRESS_RESET;
         timeout_ff     <= mrfr_pkg::BYTE_TIMEOUT_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            mrfr_pkg::CSR_OWN_ADDRESS:  own_address_ff <= csr_wdata[7:0];
            mrfr_pkg::CSR_BYTE_TIMEOUT: timeout_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_cmd_ff  <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   mrfr_frame_fsm #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_fsm (
      .clock              (clock),
      .reset              (reset),
      .fire               (fire),
      .cmd                (in_cmd_ff),
      .rx_byte            (in_byte_ff),
      .own_address        (own_address_ff),
      .byte_timeout_ticks (timeout_ff),
      .result             (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= result.valid;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && result.valid) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_ff.frame_end;
   assign rsp_tdata  = {4'd0, out_ff.frame_length, out_ff.function_code, out_ff.status,
                        out_ff.byte_position, out_ff.byte_out};

   a_end_has_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[18:16] != mrfr_pkg::ST_BUSY)))
      else $error("frame end and status disagree");

   a_timeout_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[18:16] == mrfr_pkg::ST_TIMEOUT |-> rsp_tdata[15:0] == 16'd0)
      else $error("timeout result carries a byte");

   a_stalled_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_cmd_ff))
      else $error("pending request lost while output stalled");

   a_position_follows_length: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[18:16] != mrfr_pkg::ST_TIMEOUT
      |-> rsp_tdata[35:27] == {1'b0, rsp_tdata[15:8]} + 9'd1)
      else $error("byte position and frame length disagree");

endmodule
